@@ rtl/core/kci_pkg.sv @@
// ----------------------------------------------------------------------------
// kci_pkg
// Types, codes and constants for the keyframe camera interpolator.
// ----------------------------------------------------------------------------
`default_nettype none
package kci_pkg;

  localparam int ANIM_COUNT_DEF = 4;
  localparam int MAX_KEYS_DEF   = 16;

  localparam int CHAN_W     = 4;
  localparam int WORD_W     = 32;
  localparam int DUR_W      = 16;
  localparam int NUM_CHAN   = 9;
  localparam int ROT_FIRST  = 6;
  localparam logic [CHAN_W-1:0] DUR_WORD = 4'd9;

  localparam int DIFF_W     = 34;
  localparam int MAG_W      = 34;
  localparam int DIV_W      = MAG_W + DUR_W;
  localparam int DIV_CW     = 6;
  localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(DIV_W - 1);
  localparam int SUM_W      = DIV_W + 2;

  localparam logic signed [DIFF_W-1:0] PI_Q     = 34'sd205887;
  localparam logic signed [DIFF_W-1:0] TWO_PI_Q = 34'sd411775;

  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 296;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_HEADER = 2'd2,
    FUNC_START  = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DUR0,
    ST_MODLD,
    ST_MODRUN,
    ST_STEP,
    ST_DUR1,
    ST_DUR1W,
    ST_RDA,
    ST_RDB,
    ST_DIFF,
    ST_MUL,
    ST_DIVRUN,
    ST_ACC,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

@@ rtl/core/keyframe_camera_interpolator.sv @@
// ----------------------------------------------------------------------------
// keyframe_camera_interpolator
// Keyframe sequencer with shortest-path linear interpolation in Q16.16.
// ----------------------------------------------------------------------------
// A tick runs through one shared restoring divider, one bit a cycle over
// 50 steps: once for the key modulo and once per channel for the lerp
// fraction. A zero key count skips the modulo and a zero duration skips the
// channel divides. A stalled output holds the sequencer until the result is
// taken. The key store is a memory with one write and one read port of
// ANIM_COUNT * 2^ceil(log2 MAX_KEYS) * 16 words; entries must be written
// before a tick reads them.
`default_nettype none
module keyframe_camera_interpolator #(
  parameter int ANIM_COUNT = kci_pkg::ANIM_COUNT_DEF,
  parameter int MAX_KEYS   = kci_pkg::MAX_KEYS_DEF
) (
  input  wire  logic                          clk,
  input  wire  logic                          rst,
  input  wire  logic                          s_tvalid,
  output logic                                s_tready,
  // anim_sel, key_index, channel, value, key_count, loop_enable
  input  wire  logic [kci_pkg::S_DATA_W-1:0]  s_tdata,
  // func
  input  wire  logic [1:0]                    s_tuser,
  output logic                                m_tvalid,
  input  wire  logic                          m_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, rot_x, rot_y, rot_z,
  // finished, key_now, zero pad
  output logic [kci_pkg::M_DATA_W-1:0]        m_tdata
);
  import kci_pkg::*;

  localparam int AW    = (ANIM_COUNT > 1) ? $clog2(ANIM_COUNT) : 1;
  localparam int KW    = $clog2(MAX_KEYS);
  localparam int CW    = $clog2(MAX_KEYS + 1);
  localparam int ADR_W = AW + KW + CHAN_W;
  localparam int DEPTH = ANIM_COUNT * (1 << KW) * 16;

  state_t state, state_next;

  logic [WORD_W-1:0]  mem [DEPTH];
  logic [WORD_W-1:0]  rdata;
  logic [ADR_W-1:0]   raddr;

  logic [CW-1:0]      counts [ANIM_COUNT];
  logic               loops  [ANIM_COUNT];
  logic [AW-1:0]      active;
  logic [KW-1:0]      cur;
  logic [KW-1:0]      fol;
  logic [DUR_W-1:0]   frame;
  logic               finish;

  logic [DUR_W-1:0]   dur0;
  logic [DUR_W-1:0]   dur;
  logic [3:0]         chan_j;
  logic [WORD_W-1:0]  wa;
  logic signed [DIFF_W-1:0] diff;
  logic               neg;
  logic [WORD_W-1:0]  outw [NUM_CHAN];

  logic [DUR_W-1:0]   div_rem;
  logic [DIV_W-1:0]   div_quot;
  logic [DUR_W-1:0]   div_den;
  logic [DIV_CW-1:0]  div_cnt;

  logic               accept;
  func_t              func;
  logic [1:0]         f_sel;
  logic [3:0]         f_key;
  logic [3:0]         f_chan;
  logic [WORD_W-1:0]  f_val;
  logic [4:0]         f_kcnt;
  logic               f_lp;
  logic               sel_ok;
  logic               key_ok;
  logic               chan_ok;
  logic [7:0]         sel_ext;
  logic [7:0]         key_ext;
  logic [AW-1:0]      sel_idx;
  logic [KW-1:0]      key_idx;

  logic [CW-1:0]      n_now;
  logic               n_zero;
  logic [KW-1:0]      mod_res;
  logic [16:0]        fc1;
  logic               out_load;

  logic [DUR_W:0]     shifted;
  logic [DUR_W:0]     trial;
  logic               div_ok;

  logic signed [DIFF_W-1:0] diff_raw;
  logic signed [DIFF_W-1:0] diff_adj;
  logic [MAG_W-1:0]         mag;
  logic [DIV_W-1:0]         quot;
  logic signed [SUM_W-1:0]  sq;
  logic signed [SUM_W-1:0]  sum;
  logic [WORD_W-1:0]        sat;
  logic [KW+3:0]            key_now_ext;

  assign func    = func_t'(s_tuser);
  assign f_sel   = s_tdata[1:0];
  assign f_key   = s_tdata[5:2];
  assign f_chan  = s_tdata[9:6];
  assign f_val   = s_tdata[41:10];
  assign f_kcnt  = s_tdata[46:42];
  assign f_lp    = s_tdata[47];
  assign accept  = s_tvalid && s_tready;
  assign sel_ext = {6'b0, f_sel};
  assign key_ext = {4'b0, f_key};
  assign sel_idx = sel_ext[AW-1:0];
  assign key_idx = key_ext[KW-1:0];
  assign sel_ok  = {1'b0, sel_ext} < 9'(ANIM_COUNT);
  assign key_ok  = {1'b0, key_ext} < 9'(MAX_KEYS);
  assign chan_ok = f_chan <= DUR_WORD;

  assign n_now   = counts[active];
  assign n_zero  = (n_now == '0);
  assign mod_res = div_rem[KW-1:0];
  assign fc1     = {1'b0, frame} + 17'd1;

  assign shifted = {div_rem, div_quot[DIV_W-1]};
  assign trial   = shifted - {1'b0, div_den};
  assign div_ok  = (shifted >= {1'b0, div_den});

  assign diff_raw = DIFF_W'($signed(rdata)) - DIFF_W'($signed(wa));

  always_comb begin
    diff_adj = diff_raw;
    if (chan_j >= 4'(ROT_FIRST)) begin
      if (diff_raw >= PI_Q) begin
        diff_adj = diff_raw - TWO_PI_Q;
      end else if (diff_raw <= -PI_Q) begin
        diff_adj = diff_raw + TWO_PI_Q;
      end
    end
  end

  assign mag  = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
  assign quot = (dur == '0) ? '0 : div_quot;
  assign sq   = neg ? -$signed({2'b0, quot}) : $signed({2'b0, quot});
  assign sum  = SUM_W'($signed(wa)) + sq;

  always_comb begin
    if (sum > SUM_W'(32'sh7FFF_FFFF)) begin
      sat = 32'h7FFF_FFFF;
    end else if (sum < -SUM_W'(33'sh0_8000_0000)) begin
      sat = 32'h8000_0000;
    end else begin
      sat = sum[WORD_W-1:0];
    end
  end

  assign key_now_ext = {4'b0, cur};

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    raddr      = {active, cur, DUR_WORD};
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && func == FUNC_TICK) begin
          state_next = ST_DUR0;
        end
      end
      ST_DUR0: begin
        state_next = ST_MODLD;
      end
      ST_MODLD: begin
        state_next = n_zero ? ST_STEP : ST_MODRUN;
      end
      ST_MODRUN: begin
        if (div_cnt == DIV_LAST) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        state_next = ST_DUR1;
      end
      ST_DUR1: begin
        state_next = ST_DUR1W;
      end
      ST_DUR1W: begin
        state_next = ST_RDA;
      end
      ST_RDA: begin
        raddr      = {active, cur, chan_j};
        state_next = ST_RDB;
      end
      ST_RDB: begin
        raddr      = {active, fol, chan_j};
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = (dur == '0) ? ST_ACC : ST_DIVRUN;
      end
      ST_DIVRUN: begin
        if (div_cnt == DIV_LAST) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        state_next = (chan_j == 4'(NUM_CHAN - 1)) ? ST_DONE : ST_RDA;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Key store
  always_ff @(posedge clk) begin
    if (accept && func == FUNC_WRITE && sel_ok && key_ok && chan_ok) begin
      mem[{sel_idx, key_idx, f_chan}] <=
        (f_chan == DUR_WORD) ? {16'b0, f_val[15:0]} : f_val;
    end
    rdata <= mem[raddr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ANIM_COUNT; i++) begin
        counts[i] <= '0;
        loops[i]  <= 1'b0;
      end
      active <= '0;
      cur    <= '0;
      fol    <= '0;
      frame  <= '0;
      finish <= 1'b0;
    end else begin
      if (accept && func == FUNC_HEADER && sel_ok) begin
        counts[sel_idx] <= ({4'b0, f_kcnt} > 9'(MAX_KEYS)) ? CW'(MAX_KEYS) : CW'(f_kcnt);
        loops[sel_idx]  <= f_lp;
      end
      if (accept && func == FUNC_START && sel_ok) begin
        active <= sel_idx;
        cur    <= '0;
        fol    <= '0;
        frame  <= '0;
        finish <= 1'b0;
      end
      if (state == ST_STEP) begin
        if (!n_zero) begin
          fol <= mod_res;
        end
        if (fc1 >= {1'b0, dur0}) begin
          frame <= '0;
          if (!n_zero) begin
            cur <= mod_res;
          end
          if ((n_zero || (9'(mod_res) + 9'd1 >= 9'(n_now))) && !loops[active]) begin
            finish <= 1'b1;
          end
        end else begin
          frame <= fc1[DUR_W-1:0];
        end
      end
    end
  end

  // Datapath and shared divider
  always_ff @(posedge clk) begin
    unique case (state)
      ST_MODLD: begin
        dur0     <= rdata[DUR_W-1:0];
        div_rem  <= '0;
        div_quot <= DIV_W'({1'b0, cur} + 9'd1);
        div_den  <= DUR_W'(n_now);
        div_cnt  <= '0;
      end
      ST_MODRUN, ST_DIVRUN: begin
        div_rem  <= div_ok ? trial[DUR_W-1:0] : shifted[DUR_W-1:0];
        div_quot <= {div_quot[DIV_W-2:0], div_ok};
        div_cnt  <= div_cnt + DIV_CW'(1);
      end
      ST_DUR1W: begin
        dur    <= rdata[DUR_W-1:0];
        chan_j <= '0;
      end
      ST_RDB: begin
        wa <= rdata;
      end
      ST_DIFF: begin
        diff <= diff_adj;
      end
      ST_MUL: begin
        neg      <= diff[DIFF_W-1];
        div_rem  <= '0;
        div_quot <= DIV_W'(mag) * DIV_W'(frame);
        div_den  <= dur;
        div_cnt  <= '0;
      end
      ST_ACC: begin
        outw[chan_j] <= sat;
        chan_j       <= chan_j + 4'd1;
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {3'b0, key_now_ext[3:0], finish,
                  outw[8], outw[7], outw[6], outw[5], outw[4],
                  outw[3], outw[2], outw[1], outw[0]};
    end
  end

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == ST_IDLE)
    else $error("ready outside idle");
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MODRUN || state == ST_DIVRUN) |-> div_cnt <= DIV_LAST)
    else $error("divider overran");
  a_key_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, key_now_ext} < (KW+5)'(MAX_KEYS)))
    else $error("key out of range");
  a_finish_sticky: assert property (@(posedge clk) disable iff (rst)
    finish && !(accept && func == FUNC_START) |=> finish)
    else $error("finish dropped");
`endif

endmodule
`default_nettype wire

@@ test/keyframe_camera_checker.sv @@
// ----------------------------------------------------------------------------
// keyframe_camera_checker
// Watches both stream channels of the keyframe camera interpolator. It keeps
// its own copy of the key store and sequencer state, works out the camera
// pose that each accepted tick must produce, and compares every output
// transaction field by field against the oldest expected pose.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module keyframe_camera_checker (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  input  wire logic                         s_tready,
  input  wire logic [kci_pkg::S_DATA_W-1:0] s_tdata,
  input  wire logic [1:0]                   s_tuser,
  input  wire logic                         m_tvalid,
  input  wire logic                         m_tready,
  input  wire logic [kci_pkg::M_DATA_W-1:0] m_tdata,
  output int                                errors,
  output int                                pending
);
  import kci_pkg::*;

  typedef struct packed {
    logic [8:0][31:0] chans;
    logic             fin;
    logic [3:0]       key;
  } cam_pose_t;

  logic [31:0] key_mem [4][16][10];
  logic [4:0]  anim_keys [4];
  logic        anim_loop [4];
  logic [1:0]  active;
  logic [3:0]  cur_key;
  logic [3:0]  next_key;
  logic [16:0] frames;
  logic        fin_flag;
  cam_pose_t   pose_q[$];

  function automatic logic [31:0] lerp_q16(logic [31:0] a, logic [31:0] b, bit is_rot,
                                           logic [16:0] count, logic [31:0] dur);
    longint cur;
    longint diff;
    longint r;
    cur  = longint'(signed'(a));
    diff = longint'(signed'(b)) - cur;
    if (is_rot) begin
      if (diff >= 205887) diff -= 411775;
      else if (diff <= -205887) diff += 411775;
    end
    r = cur;
    if (dur != 0) r += (diff * longint'(count)) / longint'(dur);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  task automatic apply_transaction(func_t f, logic [S_DATA_W-1:0] d);
    logic [1:0]  sel;
    logic [3:0]  kidx;
    logic [3:0]  chan;
    logic [31:0] val;
    logic [4:0]  kcnt;
    int          n;
    cam_pose_t   pose;
    sel  = d[1:0];
    kidx = d[5:2];
    chan = d[9:6];
    val  = d[41:10];
    kcnt = d[46:42];
    case (f)
      FUNC_WRITE: begin
        if (chan <= DUR_WORD) key_mem[sel][kidx][chan] = (chan == DUR_WORD) ? {16'h0, val[15:0]} : val;
      end
      FUNC_HEADER: begin
        anim_keys[sel] = (kcnt > 16) ? 5'd16 : kcnt;
        anim_loop[sel] = d[47];
      end
      FUNC_START: begin
        active   = sel;
        cur_key  = 0;
        next_key = 0;
        frames   = 0;
        fin_flag = 0;
      end
      default: begin
        n = anim_keys[active];
        frames = frames + 1;
        if (n != 0) next_key = 4'((cur_key + 1) % n);
        if (32'(frames) >= key_mem[active][cur_key][DUR_WORD]) begin
          frames = 0;
          if (n != 0) cur_key = 4'((cur_key + 1) % n);
          if ((n == 0 || cur_key + 1 >= n) && !anim_loop[active]) fin_flag = 1;
        end
        for (int j = 0; j < 9; j++)
          pose.chans[j] = lerp_q16(key_mem[active][cur_key][j], key_mem[active][next_key][j],
                                   j >= ROT_FIRST, frames, key_mem[active][cur_key][DUR_WORD]);
        pose.fin = fin_flag;
        pose.key = cur_key;
        pose_q.push_back(pose);
      end
    endcase
  endtask

  task automatic check_pose(logic [M_DATA_W-1:0] d);
    cam_pose_t want;
    if (pose_q.size() == 0) begin
      $display("%0t: unexpected output transaction %h", $time, d);
      errors++;
      return;
    end
    want = pose_q.pop_front();
    for (int j = 0; j < 9; j++)
      if (d[32*j +: 32] !== want.chans[j]) begin
        $display("%0t: channel %0d expected %h actual %h", $time, j, want.chans[j], d[32*j +: 32]);
        errors++;
      end
    if (d[288] !== want.fin) begin
      $display("%0t: finished expected %b actual %b", $time, want.fin, d[288]);
      errors++;
    end
    if (d[292:289] !== want.key) begin
      $display("%0t: key_now expected %0d actual %0d", $time, want.key, d[292:289]);
      errors++;
    end
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 4; a++) begin
        anim_keys[a] = 0;
        anim_loop[a] = 0;
      end
      active   = 0;
      cur_key  = 0;
      next_key = 0;
      frames   = 0;
      fin_flag = 0;
      pose_q.delete();
    end else begin
      if (m_tvalid && m_tready) check_pose(m_tdata);
      if (s_tvalid && s_tready) apply_transaction(func_t'(s_tuser), s_tdata);
    end
    pending = pose_q.size();
  end

endmodule

@@ test/tb_keyframe_camera_interpolator.sv @@
// ----------------------------------------------------------------------------
// tb_keyframe_camera_interpolator
// Drives key writes, headers, starts and ticks into the interpolator with
// bursty input and a stalling output side, including one long output hold.
// Animations only ever read keys that were fully written beforehand.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_keyframe_camera_interpolator;
  import kci_pkg::*;

  logic                clk = 0;
  logic                rst = 1;
  logic                s_tvalid = 0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [1:0]          s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 0;
  logic [M_DATA_W-1:0] m_tdata;
  int                  errors;
  int                  pending;

  logic [9:0]  chan_mask [4][16];
  logic [1:0]  live_anim;
  int          items;
  int          burst_left;
  logic        hold_req = 0;
  logic        hold_done;
  int          hold_left;
  int          mode;
  int          mode_left;

  keyframe_camera_interpolator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  keyframe_camera_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(errors), .pending(pending)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 0;
      hold_done <= 0;
      hold_left <= 0;
      mode      <= 0;
      mode_left <= 0;
    end else if (hold_left > 0) begin
      m_tready  <= 0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_tready  <= 0;
      hold_done <= 1;
      hold_left <= 5000;
    end else begin
      if (mode_left == 0) begin
        mode      <= $urandom_range(0, 2);
        mode_left <= $urandom_range(50, 2000);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (mode)
        0: m_tready <= 1;
        1: m_tready <= $urandom_range(0, 1);
        default: m_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic send(func_t f, logic [1:0] sel, logic [3:0] kidx, logic [3:0] chan,
                      logic [31:0] val, logic [4:0] kcnt, logic lp);
    if (burst_left == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    s_tvalid <= 1;
    s_tuser  <= f;
    s_tdata  <= {lp, kcnt, val, chan, kidx, sel};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (f == FUNC_WRITE && chan <= DUR_WORD) chan_mask[sel][kidx][chan] = 1;
    if (f == FUNC_START) live_anim = sel;
    items++;
  endtask

  function automatic int lead_keys(int a);
    int k;
    k = 0;
    while (k < 16 && chan_mask[a][k] == 10'h3FF) k++;
    return k;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 411775 * 2) - 411775;
      3: return $urandom_range(0, 40000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_dur();
    logic [31:0] v;
    v = $urandom;
    v[15:0] = ($urandom_range(0, 39) == 0) ? 16'hFFFF : 16'($urandom_range(0, 5));
    return v;
  endfunction

  task automatic write_word(int a, int k, int c);
    send(FUNC_WRITE, 2'(a), 4'(k), 4'(c), (c == DUR_WORD) ? pick_dur() : pick_word(),
         5'($urandom), 1'($urandom));
  endtask

  task automatic noise();
    int a;
    int lim;
    a = $urandom_range(0, 3);
    case ($urandom_range(0, 2))
      0: send(FUNC_WRITE, 2'(a), 4'($urandom), 4'($urandom_range(10, 15)), $urandom,
              5'($urandom), 1'($urandom));
      1: write_word(a, $urandom_range(0, 15), $urandom_range(0, 9));
      default: begin
        lim = lead_keys(a);
        send(FUNC_HEADER, 2'(a), 4'($urandom), 4'($urandom), $urandom,
             (lim == 16) ? 5'($urandom) : 5'($urandom_range(0, lim)), 1'($urandom));
      end
    endcase
  endtask

  task automatic run_anim(int a, int kcnt, bit lp, int ticks);
    int n;
    n = (kcnt > 16) ? 16 : kcnt;
    for (int k = 0; k < ((n == 0) ? 1 : n); k++) begin
      if (chan_mask[a][k] != 10'h3FF) begin
        for (int c = 0; c < 10; c++) write_word(a, k, c);
      end else begin
        repeat ($urandom_range(0, 2)) write_word(a, k, $urandom_range(0, 9));
      end
    end
    send(FUNC_HEADER, 2'(a), 4'($urandom), 4'($urandom), $urandom, 5'(kcnt), lp);
    send(FUNC_START, 2'(a), 4'($urandom), 4'($urandom), $urandom, 5'($urandom), 1'($urandom));
    repeat (ticks) begin
      if ($urandom_range(0, 5) == 0) noise();
      send(FUNC_TICK, 2'($urandom), 4'($urandom), 4'($urandom), $urandom, 5'($urandom),
           1'($urandom));
    end
  endtask

  initial begin
    logic [31:0] rk0 [10];
    logic [31:0] rk1 [10];
    bit          big_done;
    items      = 0;
    burst_left = 0;
    big_done   = 0;
    live_anim  = 0;
    for (int a = 0; a < 4; a++)
      for (int k = 0; k < 16; k++) chan_mask[a][k] = '0;
    repeat (12) @(posedge clk);
    rst <= 0;

    // saturation extremes, shortest-path rotation around pi, zero duration
    rk0 = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_0000,
            0, 0, 0, 32'h0000_0002};
    rk1 = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1,
            205887, -205887, 205886, 0};
    for (int c = 0; c < 10; c++)
      send(FUNC_WRITE, 2'd2, 4'd0, 4'(c), rk0[c], 5'd0, 1'b0);
    for (int c = 0; c < 10; c++)
      send(FUNC_WRITE, 2'd2, 4'd1, 4'(c), rk1[c], 5'd31, 1'b1);
    send(FUNC_HEADER, 2'd2, 4'd0, 4'd0, 32'd0, 5'd2, 1'b0);
    send(FUNC_START, 2'd2, 4'd0, 4'd0, 32'd0, 5'd0, 1'b0);
    repeat (5) send(FUNC_TICK, 2'd0, 4'd0, 4'd0, 32'd0, 5'd0, 1'b0);

    while (items < 420) begin
      if (items > 250) hold_req <= 1;
      if (!big_done && items > 150) begin
        big_done = 1;
        run_anim($urandom_range(0, 3), $urandom_range(16, 31), 1'($urandom), 40);
      end else begin
        case ($urandom_range(0, 3))
          0: run_anim($urandom_range(0, 3), 0, 1'($urandom), $urandom_range(2, 6));
          default: run_anim($urandom_range(0, 3), $urandom_range(1, 4), 1'($urandom),
                            $urandom_range(6, 24));
        endcase
      end
    end
    s_tvalid <= 0;

    do @(negedge clk); while (pending != 0);
    repeat (700) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/kci_pkg.sv
rtl/core/keyframe_camera_interpolator.sv
test/keyframe_camera_checker.sv
test/tb_keyframe_camera_interpolator.sv
